// ----- rtl/lmb_pkg.sv -----
// Shared constants and types for the multiword limb ALU.
// No dependencies; every other file in rtl/ imports this package.
package lmb_pkg;

  localparam int LIMB_W = 32;
  localparam int HI_W = LIMB_W + 2;
  localparam int MAC_CNT_W = $clog2(LIMB_W);
  localparam int DIV_CNT_W = $clog2(2 * LIMB_W);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_MADD = 3'd3;
  localparam logic [2:0] OP_MSUB = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;

  // Start command for a serial unit. For the multiplier, variant selects the
  // serial subtract from r; for the divider, it selects the 64-step dividend.
  typedef struct packed {
    logic start;
    logic variant;
  } lmb_cmd_t;

endpackage

// ----- rtl/lmb_mac.sv -----
// Bit-serial multiply-accumulate unit with an optional serial subtract from r.
// Depends on lmb_pkg.
module lmb_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lmb_pkg::lmb_cmd_t              cmd_i,
  input  logic [lmb_pkg::LIMB_W-1:0]     mplier_i,
  input  logic [lmb_pkg::LIMB_W-1:0]     mcand_i,
  input  logic [lmb_pkg::LIMB_W:0]       addend_i,
  input  logic [lmb_pkg::LIMB_W-1:0]     r_i,
  output logic                           done_o,
  output logic [lmb_pkg::LIMB_W-1:0]     res_o,
  output logic [lmb_pkg::LIMB_W-1:0]     carry_o
);
  import lmb_pkg::*;

  logic                 busy_q;
  logic [MAC_CNT_W-1:0] cnt_q;
  logic [HI_W-1:0]      hi_q, hi_d, sum;
  logic [LIMB_W-1:0]    mplier_q, mcand_q, prod_q, r_q;
  logic                 bw_q, bw_d, sub_q, p_bit, res_bit;

  // One partial product per cycle; the low product bit leaves the
  // accumulator and, when subtracting, meets the matching bit of r.
  always_comb begin
    sum     = hi_q + {2'b00, (mplier_q[0] ? mcand_q : '0)};
    p_bit   = sum[0];
    hi_d    = {1'b0, sum[HI_W-1:1]};
    res_bit = sub_q ? (p_bit ^ r_q[0] ^ bw_q) : p_bit;
    bw_d    = (~r_q[0] & (p_bit | bw_q)) | (p_bit & bw_q);
  end

  assign done_o  = busy_q && (cnt_q == '0);
  assign res_o   = prod_q;
  assign carry_o = hi_q[LIMB_W-1:0] + {{(LIMB_W-1){1'b0}}, bw_q & sub_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= MAC_CNT_W'(LIMB_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hi_q     <= {1'b0, addend_i};
      mplier_q <= mplier_i;
      mcand_q  <= mcand_i;
      r_q      <= r_i;
      sub_q    <= cmd_i.variant;
      bw_q     <= 1'b0;
    end else if (busy_q) begin
      hi_q     <= hi_d;
      mplier_q <= {1'b0, mplier_q[LIMB_W-1:1]};
      r_q      <= {1'b0, r_q[LIMB_W-1:1]};
      prod_q   <= {res_bit, prod_q[LIMB_W-1:1]};
      bw_q     <= bw_d;
    end
  end

endmodule

// ----- rtl/lmb_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on lmb_pkg.
module lmb_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lmb_pkg::lmb_cmd_t              cmd_i,
  input  logic [lmb_pkg::LIMB_W-1:0]     divisor_i,
  input  logic [lmb_pkg::LIMB_W-1:0]     rem_init_i,
  input  logic [2*lmb_pkg::LIMB_W-1:0]   dividend_i,
  output logic                           done_o,
  output logic [lmb_pkg::LIMB_W-1:0]     quo_o,
  output logic [lmb_pkg::LIMB_W-1:0]     rem_o
);
  import lmb_pkg::*;

  logic                  busy_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [LIMB_W-1:0]     rem_q, rem_d, quo_q, dsr_q;
  logic [2*LIMB_W-1:0]   dvd_q;
  logic [LIMB_W:0]       trial, diff;
  logic                  ge;

  // The remainder stays below the divisor, so the trial value fits in
  // one extra bit and the restored remainder in a limb.
  always_comb begin
    trial = {rem_q, dvd_q[2*LIMB_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
    rem_d = ge ? diff[LIMB_W-1:0] : trial[LIMB_W-1:0];
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.variant ? DIV_CNT_W'(2 * LIMB_W - 1) : DIV_CNT_W'(LIMB_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= rem_init_i;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[2*LIMB_W-2:0], 1'b0};
      quo_q <= {quo_q[LIMB_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/multiword_limb_alu.sv -----
// Top level of the multiword limb ALU: handshakes, running carry state and
// sequencing of the serial units. Depends on lmb_pkg, lmb_mac and lmb_div.
//
//   Channel  Valid / stall              Payload ports
//   input    in_valid_i / in_stall_o    op_i a_digit_i r_digit_i ... first_i last_i (8)
//   output   out_valid_o / out_stall_i  result_digit_o ... divide_by_zero_o (4)
//
// Add, subtract and the three multiply forms run through the bit-serial
// multiply-accumulate unit, one multiplier bit per cycle over 32 steps; the
// next input beat is taken only once the result has gone to the output
// register. Divide runs the restoring divider one quotient bit per cycle for
// each bit of a, or for each bit of a 64-bit dividend when the running
// remainder is not below the divisor. Divide by zero and the unused op codes
// skip the serial units and go from acceptance straight to the done state,
// which loads the output register.
// Reset clears the running carry, the divide-by-zero flag and all handshake
// state. A finished result waits in the output register while a stall holds
// it; the next input beat is taken as soon as the unit has handed off.
module multiword_limb_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  op_i,
  input  logic [lmb_pkg::LIMB_W-1:0]  a_digit_i,
  input  logic [lmb_pkg::LIMB_W-1:0]  r_digit_i,
  input  logic                        a_present_i,
  input  logic [lmb_pkg::LIMB_W-1:0]  scalar_i,
  input  logic [lmb_pkg::LIMB_W-1:0]  carry_init_i,
  input  logic                        first_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lmb_pkg::LIMB_W-1:0]  result_digit_o,
  output logic [lmb_pkg::LIMB_W-1:0]  carry_out_o,
  output logic                        last_out_o,
  output logic                        divide_by_zero_o
);
  import lmb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    K_MAC,
    K_DIV,
    K_IMM
  } kind_e;

  state_e state_q;
  kind_e  kind_q, kind_d;

  logic [LIMB_W-1:0] running_q, c_eff, a_eff;
  logic              zds_q, zds_eff;
  logic              accept, out_free;

  // Immediate results, settled at acceptance.
  logic [LIMB_W-1:0] imm_res_q, imm_carry_q, imm_res_d, imm_carry_d;
  logic              imm_zds_q, imm_zds_d;
  logic              last_q;

  // Output register.
  logic              out_valid_q, last_out_q, dbz_q;
  logic [LIMB_W-1:0] res_out_q, carry_out_q;

  // Serial unit connections.
  lmb_cmd_t          mac_cmd, div_cmd;
  logic [LIMB_W-1:0] mac_mcand, mac_res, mac_carry;
  logic [LIMB_W:0]   mac_addend;
  logic              mac_done, use_r;
  logic [LIMB_W-1:0] div_rem_init, div_quo, div_rem;
  logic [2*LIMB_W-1:0] div_dividend;
  logic              div_done, div_long;

  logic [LIMB_W-1:0] fin_res, fin_carry;
  logic              fin_zds, unit_done;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    a_eff   = a_present_i ? a_digit_i : '0;
    zds_eff = first_i ? 1'b0 : zds_q;
    if (first_i) begin
      c_eff = (op_i == OP_MUL) ? carry_init_i : '0;
    end else begin
      c_eff = running_q;
    end

    // Add and subtract use the multiplier with a unit multiplicand; the
    // multiply tail past the end of a adds r to the carry with a zero
    // multiplier. Subtracting forms r - (a*b + c) bit by bit.
    use_r = (op_i == OP_ADD) || (op_i == OP_MADD) || ((op_i == OP_MUL) && !a_present_i);
    mac_addend = use_r ? ({1'b0, r_digit_i} + {1'b0, c_eff}) : {1'b0, c_eff};
    mac_mcand  = ((op_i == OP_ADD) || (op_i == OP_SUB)) ? LIMB_W'(1) : scalar_i;

    // A running remainder at or above the divisor comes from mixing ops or
    // a divide by zero; the divider then shifts through all 64 dividend bits.
    div_long     = c_eff >= scalar_i;
    div_rem_init = div_long ? '0 : c_eff;
    div_dividend = div_long ? {c_eff, a_eff} : {a_eff, {LIMB_W{1'b0}}};

    imm_res_d   = r_digit_i;
    imm_carry_d = c_eff;
    imm_zds_d   = zds_eff;
    case (op_i)
      OP_ADD, OP_SUB, OP_MUL, OP_MADD, OP_MSUB: kind_d = K_MAC;
      OP_DIV: begin
        if (scalar_i == '0) begin
          kind_d      = K_IMM;
          imm_res_d   = '1;
          imm_carry_d = a_eff;
          imm_zds_d   = 1'b1;
        end else begin
          kind_d = K_DIV;
        end
      end
      default: kind_d = K_IMM;
    endcase

    mac_cmd.start   = accept && (kind_d == K_MAC);
    mac_cmd.variant = (op_i == OP_SUB) || (op_i == OP_MSUB);
    div_cmd.start   = accept && (kind_d == K_DIV);
    div_cmd.variant = div_long;
  end

  always_comb begin
    unique case (kind_q)
      K_MAC: begin
        fin_res   = mac_res;
        fin_carry = mac_carry;
        fin_zds   = zds_q;
        unit_done = mac_done;
      end
      K_DIV: begin
        fin_res   = div_quo;
        fin_carry = div_rem;
        fin_zds   = zds_q;
        unit_done = div_done;
      end
      default: begin
        fin_res   = imm_res_q;
        fin_carry = imm_carry_q;
        fin_zds   = imm_zds_q;
        unit_done = 1'b1;
      end
    endcase
  end

  lmb_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mac_cmd),
    .mplier_i (a_eff),
    .mcand_i  (mac_mcand),
    .addend_i (mac_addend),
    .r_i      (r_digit_i),
    .done_o   (mac_done),
    .res_o    (mac_res),
    .carry_o  (mac_carry)
  );

  lmb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .divisor_i  (scalar_i),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Sequencer, running state and output register. The running carry takes
  // its cleared or preloaded value at acceptance, so codes that leave it
  // alone only need to write it back at the end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_IMM;
      running_q   <= '0;
      zds_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q    <= kind_d;
            running_q <= c_eff;
            zds_q     <= zds_eff;
            state_q   <= (kind_d == K_IMM) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (unit_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            running_q   <= fin_carry;
            zds_q       <= fin_zds;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      imm_res_q   <= imm_res_d;
      imm_carry_q <= imm_carry_d;
      imm_zds_q   <= imm_zds_d;
      last_q      <= last_i;
    end
    if ((state_q == S_DONE) && out_free) begin
      res_out_q   <= fin_res;
      carry_out_q <= fin_carry;
      last_out_q  <= last_q;
      dbz_q       <= fin_zds;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_digit_o   = res_out_q;
  assign carry_out_o      = carry_out_q;
  assign last_out_o       = last_out_q;
  assign divide_by_zero_o = dbz_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the multiword limb ALU (multiword_limb_alu).
// Depends on lmb_pkg for the limb width and the op codes; the expected limbs
// come from a predictor in this file that tracks the running carry state.
module testbench;
  import lmb_pkg::*;

  // Op codes 6 and 7 are not decoded by the block; the result echoes r.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic [LIMB_W-1:0] ALL_ONES = '1;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_HALF = 800;
  // Idle cycles at the end, more than a divide with an oversized remainder needs.
  localparam int unsigned TAIL_CYCLES = 100;

  // One input beat as the sender sees it.
  typedef struct packed {
    logic [2:0]        op;
    logic [LIMB_W-1:0] a_digit;
    logic [LIMB_W-1:0] r_digit;
    logic              a_present;
    logic [LIMB_W-1:0] scalar;
    logic [LIMB_W-1:0] carry_init;
    logic              is_first;
    logic              is_last;
  } limb_beat_t;

  // One output beat: the new limb and the running carry after it.
  typedef struct packed {
    logic [LIMB_W-1:0] digit;
    logic [LIMB_W-1:0] carry;
    logic              is_last;
    logic              div_zero;
  } limb_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Everything the testbench drives starts at a known value.
  logic              in_valid = 1'b0;
  logic [2:0]        op = OP_ADD;
  logic [LIMB_W-1:0] a_digit = '0;
  logic [LIMB_W-1:0] r_digit = '0;
  logic              a_present = 1'b0;
  logic [LIMB_W-1:0] scalar = '0;
  logic [LIMB_W-1:0] carry_init = '0;
  logic              first_limb = 1'b0;
  logic              last_limb = 1'b0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [LIMB_W-1:0] result_digit;
  logic [LIMB_W-1:0] carry_out;
  logic              last_out;
  logic              divide_by_zero;

  // Predictor state: mirrors the block's running carry and zero-divisor flag.
  logic [LIMB_W-1:0] carry_state = '0;
  logic              div_zero_state = 1'b0;

  limb_result_t expected_limbs[$];
  int unsigned  mismatch_count = 0;
  int unsigned  sent_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left = 0;
  // While set, neither side idles, so beats follow as fast as the block takes them.
  bit           quiet_stretch = 1'b0;

  multiword_limb_alu u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .a_digit_i        (a_digit),
    .r_digit_i        (r_digit),
    .a_present_i      (a_present),
    .scalar_i         (scalar),
    .carry_init_i     (carry_init),
    .first_i          (first_limb),
    .last_i           (last_limb),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_digit_o   (result_digit),
    .carry_out_o      (carry_out),
    .last_out_o       (last_out),
    .divide_by_zero_o (divide_by_zero)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Limb values lean toward the corners where carries and borrows saturate.
  function automatic logic [LIMB_W-1:0] pick_limb();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return 32'd1;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic limb_beat_t make_beat(logic [2:0] beat_op, logic [LIMB_W-1:0] a,
                                           logic [LIMB_W-1:0] r, logic present,
                                           logic [LIMB_W-1:0] s, logic [LIMB_W-1:0] cinit,
                                           logic is_first, logic is_last);
    limb_beat_t b;
    b.op = beat_op;
    b.a_digit = a;
    b.r_digit = r;
    b.a_present = present;
    b.scalar = s;
    b.carry_init = cinit;
    b.is_first = is_first;
    b.is_last = is_last;
    return b;
  endfunction

  // Predicts one output beat and advances the running carry state. All the
  // arithmetic is done at 64 bits so that wrap-around matches the hardware:
  // the upper half of a sum is the carry, the negated upper half of a
  // difference is the borrow, and a divide chains {remainder, limb}.
  function automatic limb_result_t compute_limb(limb_beat_t b);
    logic [63:0]  a64;
    logic [63:0]  r64;
    logic [63:0]  s64;
    logic [63:0]  c64;
    logic [63:0]  acc;
    logic [63:0]  quot;
    logic [63:0]  rem;
    limb_result_t res;
    a64 = b.a_present ? {32'd0, b.a_digit} : 64'd0;
    r64 = {32'd0, b.r_digit};
    s64 = {32'd0, b.scalar};
    if (b.is_first) begin
      carry_state = (b.op == OP_MUL) ? b.carry_init : '0;
      div_zero_state = 1'b0;
    end
    c64 = {32'd0, carry_state};
    res.digit = b.r_digit;
    case (b.op)
      OP_ADD: begin
        acc = a64 + r64 + c64;
        res.digit = acc[31:0];
        carry_state = acc[63:32];
      end
      OP_SUB: begin
        acc = r64 - a64 - c64;
        res.digit = acc[31:0];
        carry_state = 32'd0 - acc[63:32];
      end
      OP_MUL: begin
        // Past the end of a the multiply only folds the carry into r.
        acc = b.a_present ? (a64 * s64 + c64) : (r64 + c64);
        res.digit = acc[31:0];
        carry_state = acc[63:32];
      end
      OP_MADD: begin
        acc = a64 * s64 + r64 + c64;
        res.digit = acc[31:0];
        carry_state = acc[63:32];
      end
      OP_MSUB: begin
        acc = r64 - a64 * s64 - c64;
        res.digit = acc[31:0];
        carry_state = 32'd0 - acc[63:32];
      end
      OP_DIV: begin
        if (b.scalar == '0) begin
          res.digit = ALL_ONES;
          carry_state = a64[31:0];
          div_zero_state = 1'b1;
        end else begin
          acc = {carry_state, a64[31:0]};
          quot = acc / s64;
          rem = acc % s64;
          res.digit = quot[31:0];
          carry_state = rem[31:0];
        end
      end
      default: begin
      end
    endcase
    res.carry = carry_state;
    res.is_last = b.is_last;
    res.div_zero = div_zero_state;
    return res;
  endfunction

  task automatic report_field(input string name, input logic [LIMB_W-1:0] want,
                              input logic [LIMB_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Output side stalls: random runs of stall cycles unless a quiet stretch
  // asks for a free-flowing receiver.
  always @(posedge clk) begin : stall_gen
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (!quiet_stretch) stall_left = idle_len();
    out_stall <= (stall_left != 0);
  end

  // Both handshakes are sampled at the clock edge, before the testbench's
  // own nonblocking updates land. An accepted input beat is predicted at
  // once; an accepted output beat is compared with the oldest prediction.
  // The watchdog runs here too: it counts cycles with no beat on either side.
  always @(posedge clk) begin : limb_checker
    limb_beat_t   beat;
    limb_result_t want;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        beat = make_beat(op, a_digit, r_digit, a_present, scalar, carry_init,
                         first_limb, last_limb);
        expected_limbs.push_back(compute_limb(beat));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_limbs.size() == 0) begin
          $display("%0t ns: result beat expected none, got digit %h carry %h",
                   $time, result_digit, carry_out);
          mismatch_count++;
        end else begin
          want = expected_limbs.pop_front();
          report_field("result_digit", want.digit, result_digit);
          report_field("carry_out", want.carry, carry_out);
          report_field("last_out", {31'd0, want.is_last}, {31'd0, last_out});
          report_field("divide_by_zero", {31'd0, want.div_zero}, {31'd0, divide_by_zero});
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Presents one beat after an optional random gap and holds it until the
  // block takes it. Returns at the accepting edge.
  task automatic send_limb(input limb_beat_t b);
    int unsigned gap;
    gap = quiet_stretch ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= b.op;
    a_digit    <= b.a_digit;
    r_digit    <= b.r_digit;
    a_present  <= b.a_present;
    scalar     <= b.scalar;
    carry_init <= b.carry_init;
    first_limb <= b.is_first;
    last_limb  <= b.is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Drops valid and waits until every predicted result has come back. The
  // first edge lets the checker record a beat accepted at the previous one.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_limbs.size() != 0) @(posedge clk);
  endtask

  // One multiword operation: a run of limbs sharing the op and the scalar,
  // with first on the opening limb and last on the closing one. Operand a
  // may end early so that the tail paths run. Without the first flag the
  // chain continues whatever running value the last operation left.
  task automatic send_chain(input logic [2:0] chain_op, input int unsigned len,
                            input bit with_first);
    logic [LIMB_W-1:0] scal;
    logic [LIMB_W-1:0] cinit;
    int unsigned       a_len;
    scal = pick_limb();
    // Zero divisors are kept rare so that most divides exercise the divider.
    if (chain_op == OP_DIV && scal == '0 && $urandom_range(0, 3) != 0) scal = $urandom | 32'd1;
    cinit = $urandom_range(0, 1) ? '0 : pick_limb();
    if (chain_op == OP_DIV) a_len = len - ($urandom_range(0, 4) == 0);
    else a_len = $urandom_range(1, len);
    for (int unsigned i = 0; i < len; i++) begin
      send_limb(make_beat(chain_op, pick_limb(), pick_limb(), i < a_len, scal,
                          (i == 0) ? cinit : $urandom, with_first && i == 0, i == len - 1));
    end
  endtask

  // Carry and borrow out of all-ones limbs, and the tail past the end of a.
  task automatic test_add_sub_edges();
    send_limb(make_beat(OP_ADD, ALL_ONES, ALL_ONES, 1'b1, '0, '0, 1'b1, 1'b0));
    send_limb(make_beat(OP_ADD, '0, ALL_ONES, 1'b1, '0, '0, 1'b0, 1'b0));
    send_limb(make_beat(OP_ADD, 32'h1234_5678, ALL_ONES, 1'b0, '0, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_SUB, 32'd1, '0, 1'b1, '0, ALL_ONES, 1'b1, 1'b0));
    send_limb(make_beat(OP_SUB, ALL_ONES, '0, 1'b1, '0, '0, 1'b0, 1'b0));
    send_limb(make_beat(OP_SUB, ALL_ONES, '0, 1'b0, '0, '0, 1'b0, 1'b1));
  endtask

  // Full-scale products, the plain multiply with the largest initial carry, the multiply tail
  // that folds the carry into r, and the multiply-subtract tail borrowing
  // when r is below the borrow and not when it is above.
  task automatic test_multiply_edges();
    send_limb(make_beat(OP_MUL, ALL_ONES, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
    send_limb(make_beat(OP_MUL, ALL_ONES, ALL_ONES, 1'b0, ALL_ONES, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_MADD, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
    send_limb(make_beat(OP_MADD, ALL_ONES, ALL_ONES, 1'b0, ALL_ONES, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_MSUB, ALL_ONES, '0, 1'b1, ALL_ONES, '0, 1'b1, 1'b0));
    send_limb(make_beat(OP_MSUB, ALL_ONES, '0, 1'b0, ALL_ONES, '0, 1'b0, 1'b0));
    send_limb(make_beat(OP_MSUB, '0, ALL_ONES, 1'b0, ALL_ONES, '0, 1'b0, 1'b1));
  endtask

  // A normal division chain, a zero divisor whose flag must hold for the
  // rest of the operation, and a zero divisor past the end of a.
  task automatic test_divide_edges();
    send_limb(make_beat(OP_DIV, ALL_ONES, '0, 1'b1, 32'd7, '0, 1'b1, 1'b0));
    send_limb(make_beat(OP_DIV, '0, ALL_ONES, 1'b1, 32'd7, '0, 1'b0, 1'b0));
    send_limb(make_beat(OP_DIV, ALL_ONES, '0, 1'b0, 32'd7, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_DIV, 32'hDEAD_BEEF, '0, 1'b1, '0, '0, 1'b1, 1'b0));
    send_limb(make_beat(OP_DIV, 32'h0000_0004, '0, 1'b1, 32'd5, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_DIV, ALL_ONES, '0, 1'b0, '0, '0, 1'b1, 1'b1));
  endtask

  // Ops mixed without a first flag: a multiply leaves an all-ones carry,
  // so the add carries 2, the subtract borrows 2 and the divide starts with
  // a remainder above its divisor (the long 64-step divide).
  task automatic test_mixed_oversize();
    send_limb(make_beat(OP_MUL, ALL_ONES, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
    send_limb(make_beat(OP_ADD, ALL_ONES, ALL_ONES, 1'b1, '0, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_MUL, ALL_ONES, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
    send_limb(make_beat(OP_SUB, ALL_ONES, '0, 1'b1, '0, '0, 1'b0, 1'b1));
    send_limb(make_beat(OP_MUL, ALL_ONES, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
    send_limb(make_beat(OP_DIV, ALL_ONES, '0, 1'b1, 32'd3, '0, 1'b0, 1'b1));
  endtask

  // The spare op codes echo r; first still clears the running value.
  task automatic test_unused_ops();
    send_limb(make_beat(OP_SPARE6, ALL_ONES, 32'hA5A5_5A5A, 1'b1, ALL_ONES, ALL_ONES,
                        1'b1, 1'b0));
    send_limb(make_beat(OP_SPARE7, '0, ALL_ONES, 1'b0, '0, '0, 1'b0, 1'b1));
  endtask

  // Mostly well-formed operations of one to eight limbs with random content,
  // plus chains without a first flag and single beats with every field
  // random (spare op codes included). Now and then a stretch runs with no
  // idling on either side.
  task automatic test_random_chains(input int unsigned n_items);
    int unsigned goal;
    int unsigned roll;
    goal = sent_count + n_items;
    while (sent_count < goal) begin
      if ($urandom_range(0, 19) == 0) quiet_stretch = ~quiet_stretch;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        send_chain(3'($urandom_range(0, 5)), $urandom_range(1, 8), 1'b1);
      end else if (roll < 92) begin
        send_chain(3'($urandom_range(0, 7)), $urandom_range(1, 4), 1'b0);
      end else begin
        send_limb(make_beat(3'($urandom_range(0, 7)), $urandom, $urandom, 1'($urandom),
                            $urandom, $urandom, 1'($urandom), 1'($urandom)));
      end
    end
    quiet_stretch = 1'b0;
  endtask

  // The sender holds off until the block has handed back every result, then
  // resumes: the block must start cleanly from a fully drained state.
  task automatic test_drain_pause();
    send_chain(OP_MADD, 4, 1'b1);
    wait_for_results();
    send_chain(OP_DIV, 3, 1'b1);
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_add_sub_edges();
    test_multiply_edges();
    test_divide_edges();
    test_mixed_oversize();
    test_unused_ops();
    test_random_chains(RANDOM_HALF);
    test_drain_pause();
    test_random_chains(RANDOM_HALF);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
